[rtl/vps_pkg.sv]
// Package for the Verlet particle step block: widths, register indexes,
// sequencer states and the shared fixed-point helpers. No dependencies.
package vps_pkg;

  localparam int PointCount = 256;
  localparam int FracBits   = 16;
  localparam int IdxW       = 8;
  localparam int PtW        = $clog2(PointCount);
  localparam int CfgAw      = 5;

  localparam logic [CfgAw-1:0] RegElasticity = 5'd0;
  localparam logic [CfgAw-1:0] RegDrag       = 5'd4;
  localparam logic [CfgAw-1:0] RegGravityX   = 5'd8;
  localparam logic [CfgAw-1:0] RegGravityY   = 5'd12;
  localparam logic [CfgAw-1:0] RegGravityZ   = 5'd16;
  localparam logic [CfgAw-1:0] RegTimeStep   = 5'd20;
  localparam logic [CfgAw-1:0] RegRadius     = 5'd24;

  localparam logic FuncPlace = 1'b0;
  localparam logic FuncStep  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RDW, S_SQX, S_SQY, S_SQZ, S_SQR, S_SEL,
    S_GX, S_GX1, S_GX2, S_GY, S_GY1, S_GY2, S_GZ, S_GZ1, S_GZ2,
    S_VX, S_VY, S_VZ, S_WR, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Round half up, then drop the fraction bits (arithmetic shift)
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v);
    logic signed [65:0] w;
    w = v + (66'sd1 <<< (FracBits - 1));
    return w >>> FracBits;
  endfunction

endpackage

[rtl/vps_if.sv]
// Valid/ready channel interface for the particle step block.
// Depends on vps_pkg for nothing but is generic in its payload type.
interface vps_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/verlet_particle_step_top.sv]
// Verlet particle step: top level with register file, particle memory,
// sequencer and shared multiplier. Depends on vps_pkg and vps_mul.
// Throughput: one item at a time; a new item is accepted only in S_IDLE, after the
// result of the last one has been taken. The single multiplier (one product per
// cycle, 16 uses per step) is time-shared by the sequencer. Output is held until taken.
// Reset (rst_n synchronous) clears registers to defaults and all pinned flags;
// position memories are left uninitialised.
module verlet_particle_step_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_point_index,
  input  logic signed [31:0] in_place_x,
  input  logic signed [31:0] in_place_y,
  input  logic signed [31:0] in_place_z,
  input  logic        in_place_pinned,
  input  logic signed [31:0] in_cursor_x,
  input  logic signed [31:0] in_cursor_y,
  input  logic signed [31:0] in_drag_dx,
  input  logic signed [31:0] in_drag_dy,
  input  logic        in_left_held,
  input  logic        in_right_held,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_index,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_new_z,
  output logic        out_is_selected,
  output logic        out_cut_request,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [vps_pkg::CfgAw-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vps_pkg::*;

  // configuration
  logic [30:0] elast_r, radius_r;
  logic [16:0] drag_r, dt_r;
  logic signed [31:0] gx_r, gy_r, gz_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elast_r <= 31'd65536; drag_r <= 17'd655; gx_r <= '0; gy_r <= '0; gz_r <= '0;
      dt_r <= 17'd1092; radius_r <= 31'd65536;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        RegElasticity: elast_r <= cfg_pwdata[30:0];
        RegDrag:       drag_r <= cfg_pwdata[16:0];
        RegGravityX:   gx_r <= cfg_pwdata;
        RegGravityY:   gy_r <= cfg_pwdata;
        RegGravityZ:   gz_r <= cfg_pwdata;
        RegTimeStep:   dt_r <= cfg_pwdata[16:0];
        RegRadius:     radius_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      RegElasticity: cfg_prdata = {1'b0, elast_r};
      RegDrag:       cfg_prdata = {15'd0, drag_r};
      RegGravityX:   cfg_prdata = gx_r;
      RegGravityY:   cfg_prdata = gy_r;
      RegGravityZ:   cfg_prdata = gz_r;
      RegTimeStep:   cfg_prdata = {15'd0, dt_r};
      RegRadius:     cfg_prdata = {1'b0, radius_r};
      default:       cfg_prdata = '0;
    endcase
  end

  localparam logic [16:0] One = 17'(1 << FracBits);
  logic [16:0] om, dtc;
  assign om  = One - ((drag_r > One) ? One : drag_r);
  assign dtc = (dt_r > One) ? One : dt_r;

  // particle memory: cur, prev, home as 96-bit rows
  logic [95:0] cur_mem [PointCount], prev_mem [PointCount], home_mem [PointCount];
  logic [PointCount-1:0] pinned_r;
  logic [95:0] cur_rd_r, prev_rd_r, home_rd_r;

  // item hold registers
  logic       func_r, left_r, right_r, oor_r;
  logic [7:0] idx_r;
  logic signed [31:0] px_r, py_r, pz_r, cx_r, cy_r, ddx_r, ddy_r;
  logic       ppin_r;

  state_t st_r, st_nxt;
  logic [65:0] acc_r, acc_nxt;
  logic signed [65:0] prod_r;
  logic signed [65:0] g_nxt;
  mul_req_t req;
  logic sel_r, sel_nxt;
  logic signed [31:0] ncx_r, ncy_r, ncz_r, pvx_r, pvy_r, pvz_r;
  logic signed [31:0] rx_r, ry_r, rz_r;
  logic signed [31:0] gtx_r, gty_r, gtz_r;

  logic signed [31:0] c_x, c_y, c_z, p_x, p_y, p_z;
  assign c_x = cur_rd_r[31:0];  assign c_y = cur_rd_r[63:32];  assign c_z = cur_rd_r[95:64];
  assign p_x = prev_rd_r[31:0]; assign p_y = prev_rd_r[63:32]; assign p_z = prev_rd_r[95:64];

  logic in_fire;
  assign in_ready = (st_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func; idx_r <= in_point_index; left_r <= in_left_held;
      right_r <= in_right_held; px_r <= in_place_x; py_r <= in_place_y;
      pz_r <= in_place_z; ppin_r <= in_place_pinned; cx_r <= in_cursor_x;
      cy_r <= in_cursor_y; ddx_r <= in_drag_dx; ddy_r <= in_drag_dy;
      oor_r <= ({24'd0, in_point_index} >= 32'(PointCount));
    end
  end

  // clamp and drag application
  logic signed [32:0] e33;
  logic signed [31:0] cdx, cdy;
  logic drag_on;
  assign e33 = {2'b00, elast_r};
  assign cdx = ($signed({ddx_r[31], ddx_r}) > e33) ? e33[31:0] :
               ($signed({ddx_r[31], ddx_r}) < -e33) ? 32'(-e33) : ddx_r;
  assign cdy = ($signed({ddy_r[31], ddy_r}) > e33) ? e33[31:0] :
               ($signed({ddy_r[31], ddy_r}) < -e33) ? 32'(-e33) : ddy_r;
  assign drag_on = sel_r & left_r;

  // multiplier operands
  logic signed [32:0] dxc, dyc;
  assign dxc = 33'(c_x) - 33'(cx_r);
  assign dyc = 33'(c_y) - 33'(cy_r);

  always_comb begin
    req.a = '0; req.b = '0;
    case (st_r)
      S_RDW: begin req.a = dxc; req.b = dxc; end
      S_SQX: begin req.a = dyc; req.b = dyc; end
      S_SQY: begin req.a = 33'(c_z); req.b = 33'(c_z); end
      S_SQZ: begin req.a = {2'b00, radius_r}; req.b = {2'b00, radius_r}; end
      S_SEL: begin req.a = 33'(gx_r); req.b = {16'd0, om}; end
      S_GX:  begin req.a = g_nxt[32:0]; req.b = {16'd0, dtc}; end
      S_GX1: begin req.a = g_nxt[32:0]; req.b = {16'd0, dtc}; end
      S_GX2: begin req.a = 33'(gy_r); req.b = {16'd0, om}; end
      S_GY:  begin req.a = g_nxt[32:0]; req.b = {16'd0, dtc}; end
      S_GY1: begin req.a = g_nxt[32:0]; req.b = {16'd0, dtc}; end
      S_GY2: begin req.a = 33'(gz_r); req.b = {16'd0, om}; end
      S_GZ:  begin req.a = g_nxt[32:0]; req.b = {16'd0, dtc}; end
      S_GZ1: begin req.a = g_nxt[32:0]; req.b = {16'd0, dtc}; end
      S_GZ2: begin req.a = 33'(ncx_r) - 33'(pvx_r); req.b = {16'd0, om}; end
      S_VX:  begin req.a = 33'(ncy_r) - 33'(pvy_r); req.b = {16'd0, om}; end
      S_VY:  begin req.a = 33'(ncz_r) - 33'(pvz_r); req.b = {16'd0, om}; end
      default: ;
    endcase
  end

  vps_mul u_mul (.clk(clk), .req(req), .prod_r(prod_r));

  assign g_nxt = rnd_shift(prod_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_fire) st_nxt = S_RD;
      S_RD:   st_nxt = (oor_r || func_r == FuncPlace) ? S_OUT : S_RDW;
      S_RDW:  st_nxt = S_SQX;
      S_SQX:  st_nxt = S_SQY;
      S_SQY:  st_nxt = S_SQZ;
      S_SQZ:  st_nxt = S_SQR;
      S_SQR:  st_nxt = S_SEL;
      S_SEL:  st_nxt = S_GX;
      S_GX:   st_nxt = S_GX1;
      S_GX1:  st_nxt = S_GX2;
      S_GX2:  st_nxt = S_GY;
      S_GY:   st_nxt = S_GY1;
      S_GY1:  st_nxt = S_GY2;
      S_GY2:  st_nxt = S_GZ;
      S_GZ:   st_nxt = S_GZ1;
      S_GZ1:  st_nxt = S_GZ2;
      S_GZ2:  st_nxt = S_VX;
      S_VX:   st_nxt = S_VY;
      S_VY:   st_nxt = S_VZ;
      S_VZ:   st_nxt = S_WR;
      S_WR:   st_nxt = S_OUT;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // squared-distance accumulation; a term of magnitude 2^31 or more deselects
  logic big;
  assign big = (dxc > 33'sd2147483647) || (dxc < -33'sd2147483647) ||
               (dyc > 33'sd2147483647) || (dyc < -33'sd2147483647) ||
               (c_z == 32'sh80000000);
  logic big_r;

  always_comb begin
    acc_nxt = acc_r;
    sel_nxt = sel_r;
    case (st_r)
      S_RDW:  acc_nxt = '0;
      S_SQX, S_SQY, S_SQZ: acc_nxt = acc_r + prod_r;
      S_SQR:  sel_nxt = !big_r && (acc_r < prod_r);
      default: ;
    endcase
  end

  logic [PtW-1:0] a_idx;
  assign a_idx = idx_r[PtW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pinned_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_RD && func_r == FuncPlace && !oor_r) pinned_r[a_idx] <= ppin_r;
      if (st_nxt == S_OUT && st_r != S_OUT) out_valid <= 1'b1;
      else if (st_r == S_OUT && out_ready) out_valid <= 1'b0;
    end
  end

  // memory ports: registered read in S_RD, write in S_RD or S_WR
  always_ff @(posedge clk) begin
    if (st_r == S_RD) begin
      cur_rd_r  <= cur_mem[a_idx];
      prev_rd_r <= prev_mem[a_idx];
      home_rd_r <= home_mem[a_idx];
    end
    if (st_r == S_RD && func_r == FuncPlace && !oor_r) begin
      cur_mem[a_idx]  <= {pz_r, py_r, px_r};
      prev_mem[a_idx] <= {pz_r, py_r, px_r};
      home_mem[a_idx] <= {pz_r, py_r, px_r};
    end
    if (st_r == S_WR) begin
      cur_mem[a_idx]  <= {rz_r, ry_r, rx_r};
      prev_mem[a_idx] <= {ncz_r, ncy_r, ncx_r};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sel_r <= sel_nxt;
    if (st_r == S_RDW) big_r <= big;
    case (st_r)
      S_SEL: begin
        // drag then pin
        pvx_r <= drag_on ? sat32(66'(c_x) - 66'(cdx)) : p_x;
        pvy_r <= drag_on ? sat32(66'(c_y) - 66'(cdy)) : p_y;
        pvz_r <= drag_on ? c_z : p_z;
        ncx_r <= pinned_r[a_idx] ? home_rd_r[31:0]  : c_x;
        ncy_r <= pinned_r[a_idx] ? home_rd_r[63:32] : c_y;
        ncz_r <= pinned_r[a_idx] ? home_rd_r[95:64] : c_z;
      end
      S_GX2: gtx_r <= g_nxt[31:0];
      S_GY2: gty_r <= g_nxt[31:0];
      S_GZ2: gtz_r <= g_nxt[31:0];
      S_VX:  rx_r <= sat32(66'(ncx_r) + g_nxt + 66'(gtx_r));
      S_VY:  ry_r <= sat32(66'(ncy_r) + g_nxt + 66'(gty_r));
      S_VZ:  rz_r <= sat32(66'(ncz_r) + g_nxt + 66'(gtz_r));
      default: ;
    endcase
  end

  assign out_out_index   = idx_r;
  assign out_new_x       = oor_r ? '0 : (func_r == FuncPlace) ? px_r : rx_r;
  assign out_new_y       = oor_r ? '0 : (func_r == FuncPlace) ? py_r : ry_r;
  assign out_new_z       = oor_r ? '0 : (func_r == FuncPlace) ? pz_r : rz_r;
  assign out_is_selected = !oor_r && func_r == FuncStep && sel_r;
  assign out_cut_request = out_is_selected && right_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("accepting while result pending");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT) else $error("valid outside output state");
  a_place_nosel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && func_r == FuncPlace) |-> !out_is_selected)
    else $error("place reported selected");
endmodule

[rtl/vps_mul.sv]
// Shared 33x33 signed multiplier with a registered product.
// Depends on vps_pkg.
module vps_mul (
  input  logic                     clk,
  input  vps_pkg::mul_req_t        req,
  output logic signed [65:0]       prod_r
);
  import vps_pkg::*;
  logic signed [65:0] prod_nxt;
  assign prod_nxt = req.a * req.b;
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end
endmodule

[bench/tb_top.sv]
// Self-checking bench for verlet_particle_step_top: random and directed place/step
// words, a built-in particle predictor, APB register settings per phase.
// Depends on rtl/vps_pkg.sv, rtl/vps_if.sv and rtl/verlet_particle_step_top.sv.
`timescale 1ns / 100ps

module tb_top;
  import vps_pkg::*;

  typedef struct packed {
    logic               func;
    logic [7:0]         idx;
    logic signed [31:0] px, py, pz;
    logic               pin;
    logic signed [31:0] cx, cy, ddx, ddy;
    logic               lh, rh;
  } particle_word_t;

  typedef struct packed {
    logic [7:0]         idx;
    logic signed [31:0] nx, ny, nz;
    logic               sel, cut;
  } position_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAw-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vps_if #(.payload_t(particle_word_t)) in_ch (clk);
  vps_if #(.payload_t(position_word_t)) out_ch (clk);

  verlet_particle_step_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_func(in_ch.data.func), .in_point_index(in_ch.data.idx),
    .in_place_x(in_ch.data.px), .in_place_y(in_ch.data.py), .in_place_z(in_ch.data.pz),
    .in_place_pinned(in_ch.data.pin),
    .in_cursor_x(in_ch.data.cx), .in_cursor_y(in_ch.data.cy),
    .in_drag_dx(in_ch.data.ddx), .in_drag_dy(in_ch.data.ddy),
    .in_left_held(in_ch.data.lh), .in_right_held(in_ch.data.rh),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_out_index(out_ch.data.idx), .out_new_x(out_ch.data.nx),
    .out_new_y(out_ch.data.ny), .out_new_z(out_ch.data.nz),
    .out_is_selected(out_ch.data.sel), .out_cut_request(out_ch.data.cut),
    .cfg_psel(psel), .cfg_penable(penable), .cfg_pwrite(pwrite), .cfg_paddr(paddr),
    .cfg_pwdata(pwdata), .cfg_prdata(prdata), .cfg_pready(pready)
  );

  // predictor copy of registers and particle table
  longint elast, drag_r, grav_x, grav_y, grav_z, tstep, radius;
  logic signed [31:0] cur_x[256], cur_y[256], cur_z[256];
  logic signed [31:0] prv_x[256], prv_y[256], prv_z[256];
  logic signed [31:0] hom_x[256], hom_y[256], hom_z[256];
  logic pinned[256];
  bit placed[256];

  particle_word_t pending_words[$];
  position_word_t expected_positions[$];
  int src_idle = 0, sink_stall = 0;
  int errors = 0, n_place = 0, n_step = 0, n_sel = 0, n_cut = 0, n_out = 0;
  bit hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #4ms;
    $display("verlet_particle_step_top regression: fail");
    $finish;
  end

  function automatic longint round_shift(longint v);
    return (v + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] advance(longint c, longint p, longint g,
                                                  longint om, longint dt);
    longint vel, gt;
    vel = round_shift((c - p) * om);
    gt = round_shift(g * om);
    gt = round_shift(gt * dt);
    gt = round_shift(gt * dt);
    return clip32(c + vel + gt);
  endfunction

  function automatic bit within_radius(longint dx, longint dy, longint dz);
    longint unsigned ax, ay, az;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    if (ax >= 64'd2147483648 || ay >= 64'd2147483648 || az >= 64'd2147483648) return 0;
    return ax * ax + ay * ay + az * az < longint'(radius) * longint'(radius);
  endfunction

  function automatic logic signed [31:0] clamp_delta(longint v);
    if (v > elast) return elast[31:0];
    if (v < -elast) return 32'(-elast);
    return v[31:0];
  endfunction

  function automatic void predict_word(particle_word_t w);
    position_word_t r;
    longint one, om, dt;
    logic signed [31:0] cx, cy, cz;
    int i;
    i = w.idx;
    r = '0;
    r.idx = w.idx;
    if (w.func == FuncPlace) begin
      hom_x[i] = w.px; cur_x[i] = w.px; prv_x[i] = w.px;
      hom_y[i] = w.py; cur_y[i] = w.py; prv_y[i] = w.py;
      hom_z[i] = w.pz; cur_z[i] = w.pz; prv_z[i] = w.pz;
      pinned[i] = w.pin;
      r.nx = w.px; r.ny = w.py; r.nz = w.pz;
      n_place++;
    end else begin
      one = 64'sd1 <<< FracBits;
      om = one - (drag_r > one ? one : drag_r);
      dt = tstep > one ? one : tstep;
      r.sel = within_radius(longint'(cur_x[i]) - w.cx, longint'(cur_y[i]) - w.cy,
                            longint'(cur_z[i]));
      r.cut = r.sel & w.rh;
      if (r.sel && w.lh) begin
        prv_x[i] = clip32(longint'(cur_x[i]) - clamp_delta(w.ddx));
        prv_y[i] = clip32(longint'(cur_y[i]) - clamp_delta(w.ddy));
        prv_z[i] = cur_z[i];
      end
      if (pinned[i]) begin
        cur_x[i] = hom_x[i]; cur_y[i] = hom_y[i]; cur_z[i] = hom_z[i];
      end
      cx = cur_x[i]; cy = cur_y[i]; cz = cur_z[i];
      r.nx = advance(cx, prv_x[i], grav_x, om, dt);
      r.ny = advance(cy, prv_y[i], grav_y, om, dt);
      r.nz = advance(cz, prv_z[i], grav_z, om, dt);
      prv_x[i] = cx; prv_y[i] = cy; prv_z[i] = cz;
      cur_x[i] = r.nx; cur_y[i] = r.ny; cur_z[i] = r.nz;
      n_step++;
      n_sel += r.sel;
      n_cut += r.cut;
    end
    expected_positions.push_back(r);
  endfunction

  // driver: hold the word until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= src_idle) begin
          in_ch.data <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold: count the stalled cycles
  always @(posedge clk) begin
    if (rst_n && hold_req && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end
  end

  // monitor: check each taken word, randomise ready, long hold on request
  always @(posedge clk) begin
    position_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (expected_positions.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %p", $time, out_ch.data);
        end else begin
          e = expected_positions.pop_front();
          if (out_ch.data !== e) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, out_ch.data);
          end
        end
      end
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(99) >= sink_stall;
      end
    end
  end

  task automatic write_reg(logic [CfgAw-1:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] el, logic [31:0] dg, logic [31:0] gx,
                          logic [31:0] gy, logic [31:0] gz, logic [31:0] ts,
                          logic [31:0] rd);
    write_reg(RegElasticity, el); elast = el[30:0];
    write_reg(RegDrag, dg);       drag_r = dg[16:0];
    write_reg(RegGravityX, gx);   grav_x = longint'($signed(gx));
    write_reg(RegGravityY, gy);   grav_y = longint'($signed(gy));
    write_reg(RegGravityZ, gz);   grav_z = longint'($signed(gz));
    write_reg(RegTimeStep, ts);   tstep = ts[16:0];
    write_reg(RegRadius, rd);     radius = rd[30:0];
  endtask

  task automatic drain;
    while (pending_words.size() > 0 || in_ch.valid || expected_positions.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near_val();
    return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
  endfunction

  function automatic particle_word_t place_word(int i, bit wide);
    particle_word_t w;
    w = '0;
    w.func = FuncPlace;
    w.idx = 8'(i);
    w.px = wide ? $urandom : near_val();
    w.py = wide ? $urandom : near_val();
    w.pz = wide ? $urandom : $signed($urandom_range(0, 4 << 16)) - (2 << 16);
    w.pin = $urandom_range(3) == 0;
    placed[i] = 1'b1;
    return w;
  endfunction

  function automatic particle_word_t step_word(int i, bit wide);
    particle_word_t w;
    w = $urandom;
    w = {w[$bits(w)-1:64], $urandom, $urandom};
    w.px = $urandom; w.py = $urandom; w.pz = $urandom; w.pin = 1'($urandom);
    w.func = FuncStep;
    w.idx = 8'(i);
    w.cx = wide ? $urandom : near_val();
    w.cy = wide ? $urandom : near_val();
    w.ddx = wide ? $urandom : $signed($urandom_range(0, 6 << 16)) - (3 << 16);
    w.ddy = wide ? $urandom : $signed($urandom_range(0, 6 << 16)) - (3 << 16);
    w.lh = 1'($urandom_range(1));
    w.rh = 1'($urandom_range(1));
    return w;
  endfunction

  initial begin
    particle_word_t w;
    int i;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    elast = 65536; drag_r = 655; grav_x = 0; grav_y = 0; grav_z = 0;
    tstep = 1092; radius = 65536;
    for (i = 0; i < 256; i++) pinned[i] = 1'b0;

    // directed: field extremes, pinned snap back, drag clamp, saturation
    w = '0; w.func = FuncPlace; w.idx = 8'd0;
    w.px = 32'sh7fffffff; w.py = 32'sh80000000; w.pz = 32'sh7fffffff;
    pending_words.push_back(w); placed[0] = 1'b1;
    w.idx = 8'd255; w.px = 0; w.py = 0; w.pz = 0; w.pin = 1'b1;
    pending_words.push_back(w); placed[255] = 1'b1;
    w = '0; w.func = FuncStep; w.idx = 8'd0; w.lh = 1'b1; w.rh = 1'b1;
    w.cx = 32'sh80000000; w.cy = 32'sh7fffffff;
    pending_words.push_back(w);
    w.idx = 8'd255; w.cx = 0; w.cy = 0;
    w.ddx = 32'sh7fffffff; w.ddy = 32'sh80000000;
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.lh = 1'b0; w.ddx = 32'sh80000000; w.ddy = 32'sh7fffffff;
    pending_words.push_back(w);
    w.lh = 1'b1; w.rh = 1'b0; w.ddx = 1000; w.ddy = -1000;
    pending_words.push_back(w);
    w.idx = 8'd0; w.cx = 32'sh7fffffff; w.cy = 32'sh80000000;
    pending_words.push_back(w);
    for (i = 1; i < 8; i++) begin
      pending_words.push_back(place_word(i, i > 5));
      pending_words.push_back(step_word(i, 1'b0));
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                    32'd65536, 32'h7fffffff);
        1: set_regs(0, 32'h1ffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h1ffff, 0);
        2: set_regs(32'd131072, 32'd65536, 32'hfff00000, 32'h00100000, 32'h0,
                    32'd0, 32'd196608);
        3: set_regs(32'd32768, 32'd2000, $urandom, $urandom, $urandom,
                    32'd4000, 32'd262144);
        4: set_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        default: set_regs(32'd65536, 32'd655, 32'hfff60000, 32'd0, 32'd0,
                          32'd1092, 32'd131072);
      endcase
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 49; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 49; end
        default: begin src_idle = 36; sink_stall = 36; end
      endcase
      for (int n = 0; n < 320; n++) begin
        i = $urandom_range(99) < 85 ? $urandom_range(8, 23) : $urandom_range(255);
        if (!placed[i] || $urandom_range(99) < 12)
          pending_words.push_back(place_word(i, $urandom_range(99) < 15));
        else
          pending_words.push_back(step_word(i, $urandom_range(99) < 15));
      end
      if (ph == 0) begin
        repeat (20) @(posedge clk);
        hold_req = 1'b1;
      end
      drain();
    end

    $display("covered %0d place and %0d step words, %0d selected, %0d cut, %0d checked",
             n_place, n_step, n_sel, n_cut, n_out);
    $display("seven registers swept over six settings including range limits");
    if (errors == 0) begin
      $display("verlet_particle_step_top regression: pass");
    end else begin
      $display("verlet_particle_step_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vps_pkg.sv
rtl/vps_if.sv
rtl/vps_mul.sv
rtl/verlet_particle_step_top.sv
bench/tb_top.sv
